[rtl/core/symbol_table_floor_and_name_lookup_assert.svh]
// Assertion macros for the symbol table block.
// Both macros expect clk and rst in scope.
`ifndef SYMBOL_TABLE_FLOOR_AND_NAME_LOOKUP_ASSERT_SVH
`define SYMBOL_TABLE_FLOOR_AND_NAME_LOOKUP_ASSERT_SVH
`ifndef SYNTHESIS
`define STFNL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define STFNL_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define STFNL_ASSERT(label, prop, msg)
`define STFNL_NEVER(label, cond, msg)
`endif
`endif

[rtl/core/symtab_pkg.sv]
package symtab_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int OUT_IDX_W   = 10;
  localparam int NAME_BYTES  = 8;
  localparam int NAME_W      = 8 * NAME_BYTES;
  localparam int VALUE_W     = 32;
  localparam int SECT_W      = 16;
  localparam int CLASS_W     = 8;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int S_TDATA_W   = 248;
  localparam int M_TDATA_W   = 64;
  localparam int M_PAD_W     = M_TDATA_W - OUT_IDX_W - VALUE_W - SECT_W;
  localparam logic [CLASS_W-1:0] EXT_CLASS_RESET = 8'd2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR     = 2'd0,
    OP_APPEND    = 2'd1,
    OP_ADDR_FIND = 2'd2,
    OP_NAME_FIND = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2
  } status_t;

  // one stored symbol
  typedef struct packed {
    logic [NAME_W-1:0]  name;
    logic [VALUE_W-1:0] value;
    logic [SECT_W-1:0]  section;
    logic [CLASS_W-1:0] sclass;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // search arguments held for the whole scan
  typedef struct packed {
    logic [VALUE_W-1:0] address;
    logic [SECT_W-1:0]  sec_one;
    logic [SECT_W-1:0]  sec_two;
    logic [NAME_W-1:0]  name;
  } query_t;

  typedef struct packed {
    logic addr_hit;
    logic name_hit;
  } match_t;

  // names match up to and including the first NUL of the stored name
  function automatic logic names_equal(logic [NAME_W-1:0] a, logic [NAME_W-1:0] b);
    logic eq;
    logic live;
    eq   = 1'b1;
    live = 1'b1;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (live) begin
        if (a[8*i +: 8] != b[8*i +: 8]) begin
          eq   = 1'b0;
          live = 1'b0;
        end else if (a[8*i +: 8] == 8'd0) begin
          live = 1'b0;
        end
      end
    end
    return eq;
  endfunction

endpackage

[rtl/core/symbol_table_floor_and_name_lookup.sv]
// Symbol table with address floor search and name lookup. Items arrive on
// the s_ stream (operation in s_tuser) and give one result each on the m_
// stream (status in m_tuser). Entries live in a single-port RAM that needs
// no clearing after reset. Clear and append go from accept through the EXEC
// and DONE states to the result; a search reads one stored entry per cycle
// through the RAM port in the SCAN state. One item is worked on at a time;
// a new item is taken while the previous result still waits on m_.
// external_class_code is set by cfg_we/cfg_wdata (reset 2); the user must
// write it only while idle, as the block itself does not enforce this.
`include "symbol_table_floor_and_name_lookup_assert.svh"

module symbol_table_floor_and_name_lookup (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // new_entry_name, new_entry_value, new_entry_section, new_entry_class,
  // query_address, query_section_one, query_section_two, query_name
  input  logic [symtab_pkg::S_TDATA_W-1:0]    s_tdata,
  // operation
  input  logic [symtab_pkg::OP_W-1:0]         s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // entry_index, entry_value, entry_section, zero pad
  output logic [symtab_pkg::M_TDATA_W-1:0]    m_tdata,
  // status
  output logic [symtab_pkg::STATUS_W-1:0]     m_tuser,
  input  logic                                cfg_we,
  input  logic [symtab_pkg::CLASS_W-1:0]      cfg_wdata
);
  import symtab_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t               state;
  op_t                  op_q;
  entry_t               new_entry;
  query_t               query;
  logic [CLASS_W-1:0]   ext_class;
  logic [CNT_W-1:0]     entry_count;
  logic [CNT_W-1:0]     scan_addr;
  logic                 cmp_vld;
  logic [IDX_W-1:0]     cmp_idx;
  status_t              res_status;
  logic [IDX_W-1:0]     res_idx;
  logic [VALUE_W-1:0]   res_value;
  logic [SECT_W-1:0]    res_sect;

  logic                 s_fire;
  logic                 table_full;
  logic                 rd_issue;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_addr;
  entry_t               rd_entry;
  logic [ENTRY_W-1:0]   rd_bits;
  match_t               hit;
  logic                 out_free;
  logic [IDX_W+OUT_IDX_W-1:0] idx_ext;

  assign s_tready   = (state == ST_IDLE) && !rst;
  assign s_fire     = s_tvalid && s_tready;
  assign table_full = (entry_count >= CNT_W'(TABLE_DEPTH));
  assign rd_issue   = (state == ST_SCAN) && (scan_addr < entry_count);
  assign out_free   = !m_tvalid || m_tready;

  // one port: writes only in append, reads only in scan, so they never overlap
  assign mem_we   = (state == ST_EXEC) && (op_q == OP_APPEND) && !table_full;
  assign mem_addr = (state == ST_EXEC) ? entry_count[IDX_W-1:0] : scan_addr[IDX_W-1:0];

  symtab_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (new_entry),
    .rdata (rd_bits)
  );

  assign rd_entry = entry_t'(rd_bits);

  symtab_match u_match (
    .entry      (rd_entry),
    .query      (query),
    .ext_class  (ext_class),
    .best_value (res_value),
    .hit        (hit)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ext_class <= EXT_CLASS_RESET;
    end else if (cfg_we) begin
      ext_class <= cfg_wdata;
    end
  end

  // capture of the accepted item
  always_ff @(posedge clk) begin
    if (s_fire) begin
      op_q              <= op_t'(s_tuser);
      new_entry.name    <= s_tdata[63:0];
      new_entry.value   <= s_tdata[95:64];
      new_entry.section <= s_tdata[111:96];
      new_entry.sclass  <= s_tdata[119:112];
      query.address     <= s_tdata[151:120];
      query.sec_one     <= s_tdata[167:152];
      query.sec_two     <= s_tdata[183:168];
      query.name        <= s_tdata[247:184];
    end
  end

  // sequencer and table count
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      cmp_vld     <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_fire) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          cmp_vld <= 1'b0;
          case (op_q)
            OP_CLEAR: begin
              entry_count <= '0;
              state       <= ST_DONE;
            end
            OP_APPEND: begin
              if (!table_full) begin
                entry_count <= entry_count + CNT_W'(1);
              end
              state <= ST_DONE;
            end
            default: begin
              state <= ST_SCAN;
            end
          endcase
        end
        ST_SCAN: begin
          cmp_vld <= rd_issue;
          if (!rd_issue && !cmp_vld) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // scan address, pending compare index and running result
  always_ff @(posedge clk) begin
    case (state)
      ST_EXEC: begin
        scan_addr <= '0;
        case (op_q)
          OP_APPEND: begin
            if (table_full) begin
              res_status <= STS_FULL;
              res_idx    <= '0;
              res_value  <= '0;
              res_sect   <= '0;
            end else begin
              res_status <= STS_OK;
              res_idx    <= entry_count[IDX_W-1:0];
              res_value  <= new_entry.value;
              res_sect   <= new_entry.section;
            end
          end
          OP_CLEAR: begin
            res_status <= STS_OK;
            res_idx    <= '0;
            res_value  <= '0;
            res_sect   <= '0;
          end
          default: begin
            res_status <= STS_NOT_FOUND;
            res_idx    <= '0;
            res_value  <= '0;
            res_sect   <= '0;
          end
        endcase
      end
      ST_SCAN: begin
        if (rd_issue) begin
          scan_addr <= scan_addr + CNT_W'(1);
        end
        cmp_idx <= scan_addr[IDX_W-1:0];
        // compare the entry read last cycle
        if (cmp_vld) begin
          if ((op_q == OP_ADDR_FIND && hit.addr_hit) ||
              (op_q == OP_NAME_FIND && hit.name_hit && res_status != STS_OK)) begin
            res_status <= STS_OK;
            res_idx    <= cmp_idx;
            res_value  <= rd_entry.value;
            res_sect   <= rd_entry.section;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  assign idx_ext = {{OUT_IDX_W{1'b0}}, res_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= {{M_PAD_W{1'b0}}, res_sect, res_value, idx_ext[OUT_IDX_W-1:0]};
      m_tuser <= res_status;
    end
  end

  // checks
  `STFNL_ASSERT(a_append_count, (state == ST_EXEC && op_q == OP_APPEND && !table_full) |=> (entry_count == $past(entry_count) + CNT_W'(1)), "append did not advance count")
  `STFNL_ASSERT(a_clear_count, (state == ST_EXEC && op_q == OP_CLEAR) |=> (entry_count == '0), "clear left entries")
  `STFNL_ASSERT(a_scan_range, (state == ST_SCAN && cmp_vld) |-> ({1'b0, cmp_idx} < entry_count), "scan read past table end")
  `STFNL_NEVER(a_count_range, entry_count > CNT_W'(TABLE_DEPTH), "entry count above depth")

endmodule

[rtl/core/symtab_ram.sv]
module symtab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/core/symtab_match.sv]
module symtab_match (
  input  symtab_pkg::entry_t               entry,
  input  symtab_pkg::query_t               query,
  input  logic [symtab_pkg::CLASS_W-1:0]   ext_class,
  input  logic [symtab_pkg::VALUE_W-1:0]   best_value,
  output symtab_pkg::match_t               hit
);
  import symtab_pkg::*;

  logic is_ext;
  logic sect_ok;

  // entry qualification against one search
  assign is_ext  = (entry.sclass == ext_class);
  assign sect_ok = (entry.section == query.sec_one) || (entry.section == query.sec_two);

  // strict greater-than keeps the first entry among equal values
  assign hit.addr_hit = is_ext && sect_ok && (entry.value <= query.address) &&
                        (entry.value > best_value);
  assign hit.name_hit = is_ext && names_equal(entry.name, query.name);

endmodule

[tb/tb_symbol_table_floor_and_name_lookup.sv]
module tb_symbol_table_floor_and_name_lookup;
  import symtab_pkg::*;

  // one input item, unpacked into its fields
  typedef struct {
    op_t          op;
    logic [63:0]  new_name;
    logic [31:0]  new_value;
    logic [15:0]  new_sec;
    logic [7:0]   new_class;
    logic [31:0]  q_addr;
    logic [15:0]  q_sec1;
    logic [15:0]  q_sec2;
    logic [63:0]  q_name;
  } item_t;

  // one result item
  typedef struct {
    status_t      status;
    logic [9:0]   index;
    logic [31:0]  value;
    logic [15:0]  section;
  } sym_result_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [OP_W-1:0]      s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]  m_tuser;
  logic                 cfg_we = 1'b0;
  logic [CLASS_W-1:0]   cfg_wdata = '0;

  symbol_table_floor_and_name_lookup u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // items waiting to be offered, results waiting to come back
  item_t       pending[$];
  sym_result_t results_due[$];
  item_t       offered;

  // shadow of the table as the block should hold it
  entry_t      tbl [TABLE_DEPTH];
  int          table_fill = 0;
  logic [7:0]  ext_model = EXT_CLASS_RESET;

  // what the stimulus side believes is in the table, for picking hits
  logic [63:0] plan_names[$];
  logic [31:0] plan_values[$];
  logic [15:0] plan_secs[$];
  logic [7:0]  cur_ext = EXT_CLASS_RESET;

  // idling controls
  bit          send_fast = 1'b0;
  bit          recv_fast = 1'b0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          hold_left = 0;
  int          holds_asked = 0;
  int          holds_done = 0;
  int          mismatches = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 1000000);
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 40)
      $display("mismatch on %s: got %0h, expected %0h (t=%0t)", what, got, want, $time);
    mismatches++;
  endtask

  // names are equal up to and including the first NUL, at most 8 bytes
  function automatic bit same_name(logic [63:0] x, logic [63:0] y);
    for (int b = 0; b < 8; b++) begin
      if (x[8*b +: 8] != y[8*b +: 8]) return 1'b0;
      if (x[8*b +: 8] == 8'd0) return 1'b1;
    end
    return 1'b1;
  endfunction

  // expected result of one item; updates the shadow table
  function automatic sym_result_t table_step(item_t it);
    sym_result_t r;
    logic [31:0] best;
    bit          hit;
    entry_t      e;
    r.status  = STS_OK;
    r.index   = '0;
    r.value   = '0;
    r.section = '0;
    best      = '0;
    hit       = 1'b0;
    case (it.op)
      OP_CLEAR: table_fill = 0;
      OP_APPEND: begin
        if (table_fill >= TABLE_DEPTH) begin
          r.status = STS_FULL;
        end else begin
          e.name    = it.new_name;
          e.value   = it.new_value;
          e.section = it.new_sec;
          e.sclass  = it.new_class;
          tbl[table_fill] = e;
          r.index   = 10'(table_fill);
          r.value   = e.value;
          r.section = e.section;
          table_fill++;
        end
      end
      OP_ADDR_FIND: begin
        // floor search: strictly greater keeps the first of equal values
        for (int i = 0; i < table_fill; i++) begin
          e = tbl[i];
          if ((e.section == it.q_sec1 || e.section == it.q_sec2) &&
              e.sclass == ext_model && e.value <= it.q_addr && e.value > best) begin
            best      = e.value;
            hit       = 1'b1;
            r.index   = 10'(i);
            r.value   = e.value;
            r.section = e.section;
          end
        end
        if (!hit) r.status = STS_NOT_FOUND;
      end
      default: begin
        for (int i = 0; i < table_fill; i++) begin
          e = tbl[i];
          if (!hit && e.sclass == ext_model && same_name(e.name, it.q_name)) begin
            hit       = 1'b1;
            r.index   = 10'(i);
            r.value   = e.value;
            r.section = e.section;
          end
        end
        if (!hit) r.status = STS_NOT_FOUND;
      end
    endcase
    return r;
  endfunction

  // stimulus helpers
  function automatic item_t rand_item(op_t op);
    item_t it;
    it.op        = op;
    it.new_name  = {$urandom, $urandom};
    it.new_value = $urandom;
    it.new_sec   = 16'($urandom);
    it.new_class = 8'($urandom);
    it.q_addr    = $urandom;
    it.q_sec1    = 16'($urandom);
    it.q_sec2    = 16'($urandom);
    it.q_name    = {$urandom, $urandom};
    return it;
  endfunction

  function automatic item_t mk_append(logic [63:0] n, logic [31:0] v, logic [15:0] s,
                                      logic [7:0] c);
    item_t it;
    it = rand_item(OP_APPEND);
    it.new_name  = n;
    it.new_value = v;
    it.new_sec   = s;
    it.new_class = c;
    return it;
  endfunction

  function automatic item_t mk_addr(logic [31:0] a, logic [15:0] s1, logic [15:0] s2);
    item_t it;
    it = rand_item(OP_ADDR_FIND);
    it.q_addr = a;
    it.q_sec1 = s1;
    it.q_sec2 = s2;
    return it;
  endfunction

  function automatic item_t mk_name(logic [63:0] q);
    item_t it;
    it = rand_item(OP_NAME_FIND);
    it.q_name = q;
    return it;
  endfunction

  function automatic logic [63:0] rand_name();
    logic [63:0] n;
    int          k;
    n = '0;
    case ($urandom_range(0, 3))
      0: n = {$urandom, $urandom};
      // tiny alphabet so that duplicate names show up
      1: begin
        k = $urandom_range(1, 3);
        for (int b = 0; b < k; b++) n[8*b +: 8] = 8'($urandom_range(97, 99));
      end
      default: begin
        k = $urandom_range(0, 8);
        for (int b = 0; b < k; b++) n[8*b +: 8] = 8'($urandom_range(1, 255));
      end
    endcase
    return n;
  endfunction

  // bytes after the first NUL must not matter
  function automatic logic [63:0] junk_after_nul(logic [63:0] q);
    bit seen;
    seen = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (seen) q[8*b +: 8] = 8'($urandom);
      else if (q[8*b +: 8] == 8'd0) seen = 1'b1;
    end
    return q;
  endfunction

  function automatic logic [15:0] rand_section();
    case ($urandom_range(0, 6))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd2;
      3: return 16'h7fff;
      4: return 16'h8000;
      5: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2, 3: return $urandom;
      default: return 32'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic logic [7:0] rand_class();
    if ($urandom_range(0, 9) < 7) return cur_ext;
    return 8'($urandom);
  endfunction

  // queue an item and track what the table will hold
  function automatic void push_item(item_t it);
    pending.push_back(it);
    if (it.op == OP_CLEAR) begin
      plan_names.delete();
      plan_values.delete();
      plan_secs.delete();
    end else if (it.op == OP_APPEND && plan_names.size() < TABLE_DEPTH) begin
      plan_names.push_back(it.new_name);
      plan_values.push_back(it.new_value);
      plan_secs.push_back(it.new_sec);
    end
  endfunction

  // mostly small tables; searches aim at stored entries (address 1 in 2, name 7 in 10)
  function automatic item_t next_random_item();
    item_t       it;
    int          r;
    int          k;
    logic [63:0] q;
    r = $urandom_range(0, 99);
    k = (plan_names.size() > 0) ? $urandom_range(0, plan_names.size() - 1) : 0;
    if (r < 3 || (r < 48 && plan_names.size() >= 40)) begin
      it = rand_item(OP_CLEAR);
    end else if (r < 48) begin
      it = mk_append(rand_name(), rand_value(), rand_section(), rand_class());
    end else if (r < 74) begin
      it = mk_addr($urandom, rand_section(), rand_section());
      if (plan_names.size() > 0 && $urandom_range(0, 1)) begin
        it.q_addr = plan_values[k] + 32'($urandom_range(0, 2));
        it.q_sec1 = plan_secs[k];
      end
      if ($urandom_range(0, 9) == 0) it.q_addr = '1;
      if ($urandom_range(0, 9) == 0) it.q_addr = '0;
      if ($urandom_range(0, 3) == 0) it.q_sec2 = 16'($urandom);
    end else begin
      it = mk_name(rand_name());
      if (plan_names.size() > 0 && $urandom_range(0, 9) < 7) begin
        q = plan_names[k];
        case ($urandom_range(0, 3))
          0: q = junk_after_nul(q);
          1: begin
            r = $urandom_range(0, 63);
            q[r] = ~q[r];
          end
          default: ;
        endcase
        it.q_name = q;
      end
    end
    return it;
  endfunction

  function automatic int draw_gap(bit fast);
    if (fast || $urandom_range(0, 4) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  task automatic set_ext_class(input logic [7:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    ext_model  = v;
    cur_ext    = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // every item gives a result, so an empty result queue means idle
  task automatic wait_drained();
    do @(negedge clk);
    while (!(pending.size() == 0 && !s_tvalid && results_due.size() == 0));
    repeat (5) @(negedge clk);
  endtask

  task automatic run_random(input int n);
    repeat (n) push_item(next_random_item());
    wait_drained();
  endtask

  // sender: offers queued items, predicts each one as it is taken
  always @(posedge clk) begin : driver
    item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap  = 0;
    end else begin
      if (s_tvalid && s_tready) results_due.push_back(table_step(offered));
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending.size() > 0) begin
          it = pending.pop_front();
          offered = it;
          s_tdata  <= {it.q_name, it.q_sec2, it.q_sec1, it.q_addr,
                       it.new_class, it.new_sec, it.new_value, it.new_name};
          s_tuser  <= it.op;
          s_tvalid <= 1'b1;
          send_gap  = draw_gap(send_fast);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result against the oldest expectation
  always @(posedge clk) begin : monitor
    sym_result_t want;
    logic        rdy;
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap  = 0;
      hold_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result", 64'({m_tuser, m_tdata[57:0]}), 64'(0));
        end else begin
          want = results_due.pop_front();
          if (m_tuser != want.status)
            report_mismatch("status", 64'(m_tuser), 64'(want.status));
          if (m_tdata[9:0] != want.index)
            report_mismatch("entry_index", 64'(m_tdata[9:0]), 64'(want.index));
          if (m_tdata[41:10] != want.value)
            report_mismatch("entry_value", 64'(m_tdata[41:10]), 64'(want.value));
          if (m_tdata[57:42] != want.section)
            report_mismatch("entry_section", 64'(m_tdata[57:42]), 64'(want.section));
        end
        recv_gap = draw_gap(recv_fast);
      end
      // long back-pressure so the block fills and stalls its input
      if (holds_asked > holds_done) begin
        holds_done++;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      m_tready <= rdy;
    end
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty table, ties, zero value, section extremes, NUL handling
    push_item(mk_addr(32'hffff_ffff, 16'h0, 16'h0));
    push_item(mk_name(64'h0));
    push_item(rand_item(OP_CLEAR));
    push_item(mk_append(64'h0000_0000_6e69_616d, 32'h100, 16'd1, 8'd2));
    push_item(mk_append(64'h0000_0000_0061_6263, 32'h200, 16'd1, 8'd2));
    push_item(mk_append(64'h0000_0000_0064_6362, 32'h200, 16'd2, 8'd2));
    push_item(mk_append(64'h0000_0000_0000_007a, 32'h0, 16'd1, 8'd2));
    push_item(mk_append(64'h0000_0000_0074_7361, 32'h180, 16'd1, 8'd3));
    push_item(mk_append(64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 16'h8000, 8'd2));
    push_item(mk_append(64'h0, 32'h7fff_ffff, 16'h7fff, 8'd2));
    push_item(mk_append(64'h4142_4344_4546_4748, 32'h50, 16'd1, 8'd255));
    push_item(mk_addr(32'h1ff, 16'd1, 16'd1));
    push_item(mk_addr(32'h200, 16'd2, 16'd1));
    push_item(mk_addr(32'h0, 16'd1, 16'd2));
    push_item(mk_addr(32'hffff_ffff, 16'h8000, 16'd5));
    push_item(mk_addr(32'hffff_ffff, 16'd5, 16'd6));
    push_item(mk_addr(32'h7fff_ffff, 16'h7fff, 16'h7fff));
    push_item(mk_name(64'hdead_be00_6e69_616d));
    push_item(mk_name(64'h0000_0000_0074_7361));
    push_item(mk_name(64'hffee_0000_0000_0000));
    push_item(mk_name(64'hffff_ffff_ffff_ffff));
    push_item(mk_name(64'hfeff_ffff_ffff_ffff));
    push_item(rand_item(OP_CLEAR));
    push_item(mk_name(64'h0000_0000_6e69_616d));
    wait_drained();

    // random phases under different external classes
    set_ext_class(8'd0);
    run_random(139);

    set_ext_class(8'd255);
    recv_fast = 1'b1;
    run_random(139);
    recv_fast = 1'b0;

    set_ext_class(8'($urandom));
    send_fast = 1'b1;
    repeat (139) push_item(next_random_item());
    holds_asked++;
    wait_drained();
    send_fast = 1'b0;

    set_ext_class(8'd2);
    run_random(139);

    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
